>>> hw/rtl/mmnp_pkg.sv
// Shared types and constants for the music macro note parser.
package mmnp_pkg;

  localparam int DIVD_W = 16;   // divider dividend / quotient width
  localparam int DIVS_W = 8;    // divider divisor width
  localparam int MS_W   = 17;   // duration field width

  localparam logic [DIVD_W-1:0] MS_PER_MIN = 16'd60000;

  // Register indexes of the cfg port
  localparam logic [1:0] CFG_TEMPO  = 2'd0;
  localparam logic [1:0] CFG_LENGTH = 2'd1;
  localparam logic [1:0] CFG_OCTAVE = 2'd2;

  // One note or rest handed from the parser to the timing unit
  typedef struct packed {
    logic       is_rest;
    logic [7:0] octave;
    logic [3:0] semitone;
    logic [7:0] tempo;
    logic [7:0] len;
    logic       dot;
    logic       last;
  } evt_t;

  // Up to two events written into the queue per accepted character
  typedef struct packed {
    logic p0;
    logic p1;
    evt_t e0;
    evt_t e1;
  } push_t;

endpackage

>>> hw/rtl/mmnp_if.sv
// Valid/ready channel interfaces for song characters and note results.
interface mmnp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] song_char;
  logic       end_of_song;

  modport source (output valid, output song_char, output end_of_song, input ready);
  modport sink   (input valid, input song_char, input end_of_song, output ready);
endinterface

interface mmnp_out_if;
  logic        valid;
  logic        ready;
  logic        is_rest;
  logic [7:0]  octave_out;
  logic [3:0]  semitone;
  logic [16:0] note_ms;
  logic [16:0] sound_ms;
  logic        invalid;
  logic        last_of_run;

  modport source (output valid, output is_rest, output octave_out, output semitone,
                  output note_ms, output sound_ms, output invalid, output last_of_run,
                  input ready);
  modport sink   (input valid, input is_rest, input octave_out, input semitone,
                  input note_ms, input sound_ms, input invalid, input last_of_run,
                  output ready);
endinterface

>>> hw/rtl/mmnp_front.sv
// Character parser: settings, note/rest assembly and event generation.
module mmnp_front
  import mmnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_data,
  mmnp_in_if.sink    in_ch,
  input  logic       room2,
  output push_t      push
);

  localparam logic [7:0] RST_TEMPO  = 8'd120;
  localparam logic [6:0] RST_LENGTH = 7'd4;
  localparam logic [2:0] RST_OCTAVE = 3'd4;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_NUM      = 2'd1;
  localparam logic [1:0] PH_NOTE_ACC = 2'd2;
  localparam logic [1:0] PH_NOTE_LEN = 2'd3;

  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_T    = 3'd1;
  localparam logic [2:0] CMD_L    = 3'd2;
  localparam logic [2:0] CMD_O    = 3'd3;
  localparam logic [2:0] CMD_NOTE = 3'd4;
  localparam logic [2:0] CMD_REST = 3'd5;

  localparam logic [3:0] SEMI_B = 4'd11;

  function automatic logic [3:0] letter_semi(input logic [2:0] idx);
    logic [3:0] s;
    unique case (idx)
      3'd0:    s = 4'd9;
      3'd1:    s = 4'd11;
      3'd2:    s = 4'd0;
      3'd3:    s = 4'd2;
      3'd4:    s = 4'd4;
      3'd5:    s = 4'd5;
      3'd6:    s = 4'd7;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  logic [7:0] dflt_tempo_r;
  logic [6:0] dflt_len_r;
  logic [2:0] dflt_oct_r;

  logic [7:0] tempo_r, tempo_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] octave_r, octave_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] cmd_r, cmd_nxt;
  logic [3:0] semi_r, semi_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       dseen_r, dseen_nxt;

  logic        fire;
  logic [7:0]  c, u;
  logic        is_digit, is_sharp;
  logic [11:0] dig_sum;
  logic [7:0]  acc_dig;
  logic        dispatch;
  logic        a_v, b_v;
  evt_t        a_evt, b_evt;
  logic [7:0]  a_len, b_len;

  assign fire      = in_ch.valid & in_ch.ready;
  assign in_ch.ready = room2;
  assign c         = in_ch.song_char;
  assign u         = (c >= "a" && c <= "z") ? c - 8'd32 : c;
  assign is_digit  = (c >= "0" && c <= "9");
  assign is_sharp  = (c == "#") || (c == "+");
  assign dig_sum   = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {4'd0, c - "0"};
  assign acc_dig   = (dig_sum > 12'd255) ? 8'd255 : dig_sum[7:0];
  assign a_len     = dseen_r ? acc_r : length_r;

  always_comb begin
    tempo_nxt  = tempo_r;
    length_nxt = length_r;
    octave_nxt = octave_r;
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    semi_nxt   = semi_r;
    acc_nxt    = acc_r;
    dseen_nxt  = dseen_r;
    dispatch   = 1'b0;
    a_v        = 1'b0;
    b_v        = 1'b0;
    b_len      = 8'd0;

    a_evt.is_rest  = (cmd_r == CMD_REST);
    a_evt.octave   = octave_r;
    a_evt.semitone = (cmd_r == CMD_REST) ? 4'd0 : semi_r;
    a_evt.tempo    = tempo_r;
    a_evt.len      = a_len;
    a_evt.dot      = 1'b0;
    a_evt.last     = 1'b1;
    b_evt          = a_evt;

    if (fire) begin
      unique case (phase_r)
        PH_NUM: begin
          if (is_digit) begin
            acc_nxt   = acc_dig;
            dseen_nxt = 1'b1;
          end else if (!(c == " " && !dseen_r)) begin
            if (cmd_r == CMD_T) tempo_nxt = acc_r;
            if (cmd_r == CMD_L) length_nxt = acc_r;
            if (cmd_r == CMD_O) octave_nxt = acc_r;
            dispatch = 1'b1;
          end
        end
        PH_NOTE_ACC, PH_NOTE_LEN: begin
          if (phase_r == PH_NOTE_ACC && is_sharp && semi_r < SEMI_B) begin
            semi_nxt  = semi_r + 4'd1;
            phase_nxt = PH_NOTE_LEN;
          end else if (phase_r == PH_NOTE_ACC && c == "-" && semi_r != 4'd0) begin
            semi_nxt  = semi_r - 4'd1;
            phase_nxt = PH_NOTE_LEN;
          end else if (is_digit) begin
            acc_nxt   = acc_dig;
            dseen_nxt = 1'b1;
            phase_nxt = PH_NOTE_LEN;
          end else if (c == ".") begin
            a_v       = 1'b1;
            a_evt.dot = 1'b1;
            phase_nxt = PH_IDLE;
            cmd_nxt   = CMD_NONE;
            semi_nxt  = 4'd0;
            acc_nxt   = 8'd0;
            dseen_nxt = 1'b0;
          end else begin
            a_v      = 1'b1;
            dispatch = 1'b1;
          end
        end
        PH_IDLE: dispatch = 1'b1;
      endcase

      if (dispatch) begin
        phase_nxt = PH_IDLE;
        cmd_nxt   = CMD_NONE;
        semi_nxt  = 4'd0;
        acc_nxt   = 8'd0;
        dseen_nxt = 1'b0;
        if (u == "T" || u == "L" || u == "O") begin
          cmd_nxt   = (u == "T") ? CMD_T : (u == "L") ? CMD_L : CMD_O;
          phase_nxt = PH_NUM;
        end else if (u == "P") begin
          cmd_nxt   = CMD_REST;
          phase_nxt = PH_NOTE_LEN;
        end else if (u >= "A" && u <= "G") begin
          cmd_nxt   = CMD_NOTE;
          semi_nxt  = letter_semi(3'(u - "A"));
          phase_nxt = PH_NOTE_ACC;
        end
      end

      // end of song: close any open event with the updated state, then reload
      if (in_ch.end_of_song) begin
        b_v            = (phase_nxt == PH_NOTE_ACC) || (phase_nxt == PH_NOTE_LEN);
        b_len          = dseen_nxt ? acc_nxt : length_nxt;
        b_evt.is_rest  = (cmd_nxt == CMD_REST);
        b_evt.octave   = octave_nxt;
        b_evt.semitone = (cmd_nxt == CMD_REST) ? 4'd0 : semi_nxt;
        b_evt.tempo    = tempo_nxt;
        b_evt.len      = b_len;
        b_evt.dot      = 1'b0;
        tempo_nxt  = dflt_tempo_r;
        length_nxt = {1'b0, dflt_len_r};
        octave_nxt = {5'd0, dflt_oct_r};
        phase_nxt  = PH_IDLE;
        cmd_nxt    = CMD_NONE;
        semi_nxt   = 4'd0;
        acc_nxt    = 8'd0;
        dseen_nxt  = 1'b0;
      end
    end

    // zero-length events produce nothing
    a_v = a_v && (a_len != 8'd0);
    b_v = b_v && (b_len != 8'd0);
  end

  always_comb begin
    push.p0      = a_v | b_v;
    push.p1      = a_v & b_v;
    push.e0      = a_v ? a_evt : b_evt;
    push.e0.last = !(a_v && b_v);
    push.e1      = b_evt;
    push.e1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_tempo_r <= RST_TEMPO;
      dflt_len_r   <= RST_LENGTH;
      dflt_oct_r   <= RST_OCTAVE;
      tempo_r      <= RST_TEMPO;
      length_r     <= {1'b0, RST_LENGTH};
      octave_r     <= {5'd0, RST_OCTAVE};
      phase_r      <= PH_IDLE;
      cmd_r        <= CMD_NONE;
      semi_r       <= 4'd0;
      acc_r        <= 8'd0;
      dseen_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_TEMPO:  dflt_tempo_r <= cfg_data;
          CFG_LENGTH: dflt_len_r   <= cfg_data[6:0];
          CFG_OCTAVE: dflt_oct_r   <= cfg_data[2:0];
          default: ;
        endcase
      end
      tempo_r  <= tempo_nxt;
      length_r <= length_nxt;
      octave_r <= octave_nxt;
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      semi_r   <= semi_nxt;
      acc_r    <= acc_nxt;
      dseen_r  <= dseen_nxt;
    end
  end

  a_push_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    push.p0 |-> fire)
    else $error("event pushed without an accepted item");

endmodule

>>> hw/rtl/mmnp_fifo.sv
// Event queue between parser and timing unit: two writes, one read per cycle.
module mmnp_fifo
  import mmnp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room2,
  output logic  q_valid,
  output evt_t  q_data,
  input  logic  pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  evt_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);
  assign room2     = (count_r <= CNT_W'(DEPTH - 2));
  assign q_valid   = (count_r != '0);
  assign q_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push.p1 ? ptr_inc(wr_ptr_p1) : (push.p0 ? wr_ptr_p1 : wr_ptr_r);
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.p0) + CNT_W'(push.p1) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.p0) mem_r[wr_ptr_r] <= push.e0;
    if (push.p1) mem_r[wr_ptr_p1] <= push.e1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("event queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty event queue");

endmodule

>>> hw/rtl/mmnp_div.sv
// Restoring divider, one quotient bit per cycle.
module mmnp_div
  import mmnp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W:0]   rem_sh, rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r, quo_r[DIVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/mmnp_back.sv
// Timing unit: note duration from tempo, length and dot, plus result register.
module mmnp_back
  import mmnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  evt_t       q_data,
  output logic       pop,
  mmnp_out_if.source out_ch
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_DIV1  = 3'd1;
  localparam logic [2:0] B_DIV2  = 3'd2;
  localparam logic [2:0] B_SCALE = 3'd3;
  localparam logic [2:0] B_HOLD  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  evt_t              ev_r, ev_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [MS_W-1:0]   ms_r, ms_nxt;

  logic              div_start, div_done;
  logic [DIVD_W-1:0] div_dvd, div_quo;
  logic [DIVS_W-1:0] div_dvs;

  logic [DIVD_W+1:0] q_x3;
  logic [MS_W+1:0]   ms_x3;
  logic              load;

  logic              ov_r, rest_r, inv_r, last_r;
  logic [7:0]        oct_r;
  logic [3:0]        semi_r;
  logic [MS_W-1:0]   note_r, snd_r;

  mmnp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign q_x3  = {1'b0, quo_r, 1'b0} + {2'b00, quo_r};
  assign ms_x3 = {1'b0, ms_r, 1'b0} + {2'b00, ms_r};
  assign load  = (state_r == B_HOLD) && (!ov_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    ev_nxt    = ev_r;
    quo_nxt   = quo_r;
    ms_nxt    = ms_r;
    pop       = 1'b0;
    div_start = 1'b0;
    div_dvd   = MS_PER_MIN;
    div_dvs   = q_data.tempo;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          pop    = 1'b1;
          ev_nxt = q_data;
          if (q_data.tempo == 8'd0) begin
            quo_nxt   = '0;
            state_nxt = B_SCALE;
          end else begin
            div_start = 1'b1;
            state_nxt = B_DIV1;
          end
        end
      end
      B_DIV1: begin
        div_dvd = div_quo;
        div_dvs = ev_r.len;
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = B_DIV2;
        end
      end
      B_DIV2: begin
        if (div_done) begin
          quo_nxt   = div_quo;
          state_nxt = B_SCALE;
        end
      end
      B_SCALE: begin
        ms_nxt    = ev_r.dot ? q_x3[DIVD_W+1:1] : {1'b0, quo_r};
        state_nxt = B_HOLD;
      end
      B_HOLD: begin
        if (load) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
    ev_r  <= ev_nxt;
    quo_r <= quo_nxt;
    ms_r  <= ms_nxt;
    if (load) begin
      rest_r <= ev_r.is_rest;
      oct_r  <= ev_r.octave;
      semi_r <= ev_r.semitone;
      note_r <= ms_r;
      snd_r  <= ms_x3[MS_W+1:2];
      inv_r  <= (ev_r.tempo == 8'd0) || (!ev_r.is_rest && ev_r.octave > 8'd6);
      last_r <= ev_r.last;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.is_rest     = rest_r;
  assign out_ch.octave_out  = oct_r;
  assign out_ch.semitone    = semi_r;
  assign out_ch.note_ms     = note_r;
  assign out_ch.sound_ms    = snd_r;
  assign out_ch.invalid     = inv_r;
  assign out_ch.last_of_run = last_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == B_DIV1 || state_r == B_DIV2))
    else $error("divider finished outside a divide step");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == B_DIV1 || state_r == B_SCALE))
    else $error("popped event not taken into work");

endmodule

>>> hw/rtl/music_macro_note_parser.sv
// Top level of the music macro note parser: parser, event queue, timing unit.
//
// Usage:
//   in_ch  : one song character per item (song_char, end_of_song). Case is
//            ignored; end_of_song closes any open note or setting and reloads
//            tempo, length and octave from the cfg registers.
//   out_ch : one item per note or rest: octave, semitone, note_ms, sound_ms,
//            invalid, and last_of_run on the final item caused by a character.
//   cfg_*  : write-only defaults, index 0 tempo, 1 length, 2 octave; write
//            them only while the block is idle.
// Throughput: the parser takes one character per cycle while the event queue
//   has room for two events. The timing unit works on one note or rest at a
//   time: two 16-step divisions on one shared restoring divider
//   ((60000 / tempo) / length), a dot/scale step and the result register.
//   A zero-tempo event skips the divider.
// Reset (rst_n low, synchronous): defaults 120 / 4 / 4, parser idle, queue
//   and result register empty. A stalled receiver holds the result register;
//   the queue then fills and in_ch.ready drops.
module music_macro_note_parser
  import mmnp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_data,
  mmnp_in_if.sink    in_ch,
  mmnp_out_if.source out_ch
);

  push_t push;
  logic  room2;
  logic  q_valid;
  evt_t  q_data;
  logic  pop;

  // front: classifies characters, emits complete events into the queue
  mmnp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .room2    (room2),
    .push     (push)
  );

  // queue: decouples the parser from the slow timing unit
  mmnp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room2   (room2),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop)
  );

  // back: durations and the registered result
  mmnp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // a fresh result follows its pop, via the scale step (zero tempo) or via both divides
  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(pop, 3) || $past(pop, 37))
    else $error("result appeared without a queued event");

endmodule

>>> test/testbench.sv
// Self-checking testbench for the music macro note parser: directed songs, then random songs.
`timescale 1ns / 100ps

module testbench;
  import mmnp_pkg::*;

  localparam int SETTLE_CYCLES = 80;    // > one note through the divider
  localparam int STALL_LIMIT   = 3000;  // cycles with no item moving on either side
  localparam int PHASE_ITEMS   = 250;   // random characters per phase
  localparam int REPORT_LINES  = 200;   // keep the log short on a broken build

  // Where the parser stands between characters
  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NUMBER,      // T/L/O waiting for or reading digits
    SCAN_ACCIDENTAL,  // note letter seen, sharp/flat still allowed
    SCAN_LENGTH       // note or rest reading its length
  } scan_t;

  // Command whose text is still open
  typedef enum logic [2:0] {
    OPEN_NONE,
    OPEN_TEMPO,
    OPEN_LENGTH,
    OPEN_OCTAVE,
    OPEN_NOTE,
    OPEN_REST
  } open_t;

  typedef struct packed {
    logic            is_rest;
    logic [7:0]      octave;
    logic [3:0]      semitone;
    logic [MS_W-1:0] note_ms;
    logic [MS_W-1:0] sound_ms;
    logic            invalid;
    logic            last_of_run;
  } note_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_data;
  logic       rx_ready = 1'b0;

  mmnp_in_if  in_ch ();
  mmnp_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  music_macro_note_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Note predictor: mirrors the parser state and computes the notes and rests
  // that each accepted character completes.
  // ---------------------------------------------------------------------------
  logic [7:0] dflt_tempo = 8'd120;
  logic [6:0] dflt_len   = 7'd4;
  logic [2:0] dflt_oct   = 3'd4;

  logic [7:0] song_tempo;
  logic [7:0] song_len;
  logic [7:0] song_oct;
  scan_t      scan;
  open_t      open_cmd;
  logic [3:0] tone;
  logic [7:0] acc_value;
  logic       have_digits;
  logic       dotted;

  note_t notes_due[$];   // expected notes, oldest first
  note_t step_buf[2];    // notes of the character being predicted
  int    step_cnt;

  function void clear_open();
    scan        = SCAN_IDLE;
    open_cmd    = OPEN_NONE;
    tone        = 4'd0;
    acc_value   = 8'd0;
    have_digits = 1'b0;
    dotted      = 1'b0;
  endfunction

  function void reload_defaults();
    song_tempo = dflt_tempo;
    song_len   = {1'b0, dflt_len};
    song_oct   = {5'd0, dflt_oct};
    clear_open();
  endfunction

  // Decimal accumulate, pinned at 255
  function void take_digit(logic [7:0] c);
    int v;
    v = int'(acc_value) * 10 + int'(c - "0");
    acc_value   = (v > 255) ? 8'd255 : v[7:0];
    have_digits = 1'b1;
  endfunction

  function void commit_setting();
    case (open_cmd)
      OPEN_TEMPO:  song_tempo = acc_value;
      OPEN_LENGTH: song_len   = acc_value;
      OPEN_OCTAVE: song_oct   = acc_value;
      default: ;
    endcase
  endfunction

  // Close the open note or rest; a zero length produces nothing
  function void emit_note();
    int    span;
    int    ms;
    int    snd;
    logic  rest;
    logic  bad;
    note_t r;
    rest = (open_cmd == OPEN_REST);
    span = have_digits ? int'(acc_value) : int'(song_len);
    if (span == 0 || step_cnt >= 2) return;
    ms  = 0;
    snd = 0;
    bad = 1'b0;
    if (song_tempo == 8'd0) begin
      bad = 1'b1;
    end else begin
      ms = (int'(MS_PER_MIN) / int'(song_tempo)) / span;
      if (dotted) ms = ms * 3 / 2;
      snd = ms * 3 / 4;
    end
    // rests are never flagged for their octave
    if (!rest && song_oct > 8'd6) bad = 1'b1;
    r.is_rest     = rest;
    r.octave      = song_oct;
    r.semitone    = rest ? 4'd0 : tone;
    r.note_ms     = ms[MS_W-1:0];
    r.sound_ms    = snd[MS_W-1:0];
    r.invalid     = bad;
    r.last_of_run = 1'b0;
    step_buf[step_cnt] = r;
    step_cnt++;
  endfunction

  // A character that opens a new command (or is stray and opens nothing)
  function void start_command(logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    clear_open();
    if (u == "T" || u == "L" || u == "O") begin
      open_cmd = (u == "T") ? OPEN_TEMPO : (u == "L") ? OPEN_LENGTH : OPEN_OCTAVE;
      scan     = SCAN_NUMBER;
    end else if (u == "P") begin
      open_cmd = OPEN_REST;
      scan     = SCAN_LENGTH;
    end else if (u >= "A" && u <= "G") begin
      open_cmd = OPEN_NOTE;
      scan     = SCAN_ACCIDENTAL;
      case (u)
        "A":     tone = 4'd9;
        "B":     tone = 4'd11;
        "C":     tone = 4'd0;
        "D":     tone = 4'd2;
        "E":     tone = 4'd4;
        "F":     tone = 4'd5;
        default: tone = 4'd7;
      endcase
    end
  endfunction

  function void feed_char(logic [7:0] c);
    logic is_digit;
    is_digit = (c >= "0" && c <= "9");
    if (scan == SCAN_NUMBER) begin
      if (is_digit) begin
        take_digit(c);
        return;
      end
      // spaces only skipped ahead of the first digit
      if (c == " " && !have_digits) return;
      commit_setting();
    end else if (scan == SCAN_ACCIDENTAL || scan == SCAN_LENGTH) begin
      // sharp on B or flat on C is refused and falls through as stray
      if (scan == SCAN_ACCIDENTAL && (c == "#" || c == "+") && tone < 4'd11) begin
        tone++;
        scan = SCAN_LENGTH;
        return;
      end
      if (scan == SCAN_ACCIDENTAL && c == "-" && tone > 4'd0) begin
        tone--;
        scan = SCAN_LENGTH;
        return;
      end
      if (is_digit) begin
        take_digit(c);
        scan = SCAN_LENGTH;
        return;
      end
      if (c == ".") begin
        dotted = 1'b1;
        emit_note();
        clear_open();
        return;
      end
      emit_note();
    end
    start_command(c);
  endfunction

  function void predict_notes(logic [7:0] c, logic eos);
    step_cnt = 0;
    feed_char(c);
    if (eos) begin
      if (scan == SCAN_NUMBER) commit_setting();
      else if (scan == SCAN_ACCIDENTAL || scan == SCAN_LENGTH) emit_note();
      reload_defaults();
    end
    if (step_cnt > 0) step_buf[step_cnt-1].last_of_run = 1'b1;
    for (int i = 0; i < step_cnt; i++) notes_due.push_back(step_buf[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the note checker
  // ---------------------------------------------------------------------------
  logic in_idle_on  = 1'b1;
  logic out_idle_on = 1'b1;
  int   mismatches  = 0;
  int   notes_taken = 0;
  int   stall_mark  = 0;
  int   out_wait    = 0;
  int   chars_sent  = 0;
  int   idle_cycles = 0;

  function int draw_wait(logic on);
    return on ? int'($urandom_range(18, 0)) : 0;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LINES) $display("%t %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("note %0d: %s is %0h, expected %0h",
                                notes_taken, name, got, want));
  endtask

  always @(posedge clk) begin : check_notes
    note_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (notes_due.size() == 0) begin
        report_mismatch($sformatf("note %0d arrived with nothing expected", notes_taken));
      end else begin
        want = notes_due.pop_front();
        check_field("is_rest",     32'(out_ch.is_rest),     32'(want.is_rest));
        check_field("octave_out",  32'(out_ch.octave_out),  32'(want.octave));
        check_field("semitone",    32'(out_ch.semitone),    32'(want.semitone));
        check_field("note_ms",     32'(out_ch.note_ms),     32'(want.note_ms));
        check_field("sound_ms",    32'(out_ch.sound_ms),    32'(want.sound_ms));
        check_field("invalid",     32'(out_ch.invalid),     32'(want.invalid));
        check_field("last_of_run", 32'(out_ch.last_of_run), 32'(want.last_of_run));
      end
      notes_taken++;
    end
  end

  // New stall drawn after each accepted note; ready held low for that many cycles
  always @(negedge clk) begin
    if (notes_taken != stall_mark) begin
      stall_mark = notes_taken;
      out_wait   = draw_wait(out_idle_on);
    end
    if (out_wait > 0) begin
      rx_ready <= 1'b0;
      out_wait--;
    end else begin
      rx_ready <= 1'b1;
    end
  end

  // Watchdog: ends a run in which no item moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Character side. Every task here starts and ends at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic eos);
    int gap;
    gap = draw_wait(in_idle_on);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.song_char   = c;
    in_ch.end_of_song = eos;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predict_notes(c, eos);
    chars_sent++;
    @(negedge clk);
  endtask

  // end_of_song goes with the last character when eos_last is set
  task automatic send_text(input string s, input logic eos_last);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], eos_last && (i == s.len() - 1));
  endtask

  // Hold off the sender until every note is out and the block has settled
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (notes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Defaults take effect in the block at the next end of song
  task automatic write_defaults(input logic [7:0] tempo, input logic [6:0] length,
                                input logic [2:0] octave);
    cfg_we   = 1'b1;
    cfg_idx  = CFG_TEMPO;
    cfg_data = tempo;
    @(negedge clk);
    cfg_idx  = CFG_LENGTH;
    cfg_data = {1'b0, length};
    @(negedge clk);
    cfg_idx  = CFG_OCTAVE;
    cfg_data = {5'd0, octave};
    @(negedge clk);
    cfg_we     = 1'b0;
    dflt_tempo = tempo;
    dflt_len   = length;
    dflt_oct   = octave;
  endtask

  // ---------------------------------------------------------------------------
  // Directed songs
  // ---------------------------------------------------------------------------

  // Defaults from reset: 120 bpm, quarter notes, octave 4; comma closes the note
  task automatic test_reset_defaults();
    send_text("c4,", 1'b0);
  endtask

  // Sharp on B and flat on C are refused; '+' raises F; dot closes the note
  task automatic test_accidentals();
    send_text("B#C-f+8.", 1'b0);
  endtask

  // Sign before a number: tempo becomes 0 and the note is flagged
  task automatic test_zero_tempo_and_sign();
    send_text("T-5a.", 1'b0);
  endtask

  // Octave 9 flags the note, length 999 saturates, rest of length 0 is dropped
  task automatic test_octave_and_saturation();
    send_text("T200O9L999G P0", 1'b1);
  endtask

  // NUL and 0xff are ignored, a spaced length is stray, and one character
  // closes one note while end of song flushes the next
  task automatic test_stray_and_song_end();
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_text("e 8cD", 1'b1);
  endtask

  // Defaults at tempo 1 and 255, length 1 and 64, octave 0 and 6; longest and shortest durations
  task automatic test_config_extremes();
    wait_drained();
    write_defaults(8'd1, 7'd1, 3'd0);
    send_char(" ", 1'b1);
    send_text("c.", 1'b0);
    wait_drained();
    write_defaults(8'd255, 7'd64, 3'd6);
    send_char(" ", 1'b1);
    send_text("b", 1'b1);
    wait_drained();
    write_defaults(8'd120, 7'd4, 3'd4);
    send_char(" ", 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Random songs: mostly well-formed commands with random content, some noise
  // ---------------------------------------------------------------------------
  logic [7:0] token_chars[$];

  // Decimal text of a number, sometimes with a leading zero
  task automatic push_number(input int value);
    string digits;
    if ($urandom_range(9, 0) == 0) token_chars.push_back("0");
    digits = $sformatf("%0d", value);
    for (int i = 0; i < digits.len(); i++) token_chars.push_back(digits[i]);
  endtask

  task automatic send_random_token();
    int   pick;
    int   value;
    logic eos;
    pick = $urandom_range(99, 0);
    token_chars.delete();
    if (pick < 55) begin
      // note (letter plus optional accidental) or rest
      if (pick < 45) begin
        token_chars.push_back(8'("A") + 8'($urandom_range(6, 0)));
        case ($urandom_range(5, 0))
          0: token_chars.push_back("#");
          1: token_chars.push_back("+");
          2: token_chars.push_back("-");
          default: ;
        endcase
      end else begin
        token_chars.push_back("P");
      end
      if ($urandom_range(9, 0) < 6)
        push_number(($urandom_range(9, 0) < 8) ? $urandom_range(64, 1) : $urandom_range(999, 0));
      if ($urandom_range(9, 0) < 3) token_chars.push_back(".");
    end else if (pick < 75) begin
      // T, L or O with a number in or out of the useful range
      case ($urandom_range(2, 0))
        0: begin
          token_chars.push_back("T");
          value = ($urandom_range(9, 0) < 8) ? $urandom_range(255, 20) : $urandom_range(999, 0);
        end
        1: begin
          token_chars.push_back("L");
          value = ($urandom_range(9, 0) < 8) ? $urandom_range(64, 1) : $urandom_range(300, 0);
        end
        default: begin
          token_chars.push_back("O");
          value = ($urandom_range(9, 0) < 8) ? $urandom_range(6, 0) : $urandom_range(255, 7);
        end
      endcase
      if ($urandom_range(4, 0) == 0) repeat ($urandom_range(2, 1)) token_chars.push_back(" ");
      if ($urandom_range(9, 0) != 0) push_number(value);
    end else if (pick < 85) begin
      token_chars.push_back($urandom_range(1, 0) ? " " : ",");
    end else begin
      token_chars.push_back(8'($urandom_range(255, 0)));
    end
    // lower case for command letters half the time
    if (pick < 75 && $urandom_range(1, 0)) token_chars[0] = token_chars[0] | 8'h20;
    eos = ($urandom_range(24, 0) == 0);
    foreach (token_chars[i])
      send_char(token_chars[i], eos && (i == token_chars.size() - 1));
  endtask

  // Four phases: different defaults and every combination of idling on both sides
  task automatic test_random_songs();
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      send_char(" ", 1'b1);
      wait_drained();
      case (ph)
        0: write_defaults(8'($urandom_range(255, 1)), 7'($urandom_range(64, 1)),
                          3'($urandom_range(6, 0)));
        1: write_defaults(8'd1, 7'd1, 3'd0);
        2: write_defaults(8'd255, 7'd64, 3'd6);
        default: write_defaults(8'd120, 7'd4, 3'd4);
      endcase
      in_idle_on  = (ph == 0 || ph == 2);
      out_idle_on = (ph == 0 || ph == 3);
      send_char(" ", 1'b1);
      target = chars_sent + PHASE_ITEMS;
      while (chars_sent < target) send_random_token();
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_TEMPO;
    cfg_data          = 8'd0;
    in_ch.valid       = 1'b0;
    in_ch.song_char   = 8'd0;
    in_ch.end_of_song = 1'b0;
    reload_defaults();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_accidentals();
    test_zero_tempo_and_sign();
    test_octave_and_saturation();
    test_stray_and_song_end();
    test_config_extremes();
    test_random_songs();

    // all notes in, then a quiet stretch to catch anything extra
    wait_drained();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
